// ===== sv/virtual_path_utf8_validator_top_assert.svh =====
// Assertion macros used by the path validator core.
`ifndef VIRTUAL_PATH_UTF8_VALIDATOR_TOP_ASSERT_SVH
`define VIRTUAL_PATH_UTF8_VALIDATOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on aclk, off during reset
`define VPU8_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off during reset
`define VPU8_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/vpu8_pkg.sv =====
// Types, constants and helper functions of the virtual path validator.
`timescale 1ns / 1ps
package vpu8_pkg;

    typedef enum logic [2:0] {
        FAULT_OK        = 3'd0,
        FAULT_EMPTY     = 3'd1,
        FAULT_FORBIDDEN = 3'd2,
        FAULT_UTF8      = 3'd3,
        FAULT_SEGMENT   = 3'd4
    } fault_t;

    localparam int FLAG_FORBIDDEN = 0;
    localparam int FLAG_UTF8      = 1;
    localparam int FLAG_SEGMENT   = 2;

    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] BYTE_BACKSLASH = 8'h5c;
    localparam logic [7:0] BYTE_COLON     = 8'h3a;
    localparam logic [7:0] BYTE_SLASH     = 8'h2f;
    localparam logic [7:0] BYTE_DOT       = 8'h2e;

    localparam logic [20:0] CP_MIN_SEQ1 = 21'h00080;
    localparam logic [20:0] CP_MIN_SEQ2 = 21'h00800;
    localparam logic [20:0] CP_MIN_SEQ3 = 21'h10000;
    localparam logic [20:0] CP_SURR_LO  = 21'h0d800;
    localparam logic [20:0] CP_SURR_HI  = 21'h0dfff;
    localparam logic [20:0] CP_MAX      = 21'h10ffff;

    localparam logic [1:0] SEG_LEN_SAT = 2'd3;

    typedef struct packed {
        logic [7:0] path_byte;
        logic       last;
        logic       empty_path;
    } item_t;

    typedef struct packed {
        fault_t fault;
        logic   valid_res;
    } result_t;

    typedef struct packed {
        logic [1:0]  pend;
        logic [1:0]  seq_len;
        logic [20:0] acc;
        logic [1:0]  seg_len;
        logic        seg_dots;
        logic [2:0]  flags;
    } state_t;

    localparam state_t STATE_RESET = '{
        pend:     2'd0,
        seq_len:  2'd0,
        acc:      21'd0,
        seg_len:  2'd0,
        seg_dots: 1'b1,
        flags:    3'd0
    };

    function automatic logic seg_bad(input logic [1:0] len, input logic dots);
        seg_bad = (len == 2'd0) || (dots && (len != SEG_LEN_SAT));
    endfunction

    function automatic logic cp_bad(input logic [1:0] seq_len, input logic [20:0] cp);
        cp_bad = ((seq_len == 2'd1) && (cp < CP_MIN_SEQ1)) ||
                 ((seq_len == 2'd2) && (cp < CP_MIN_SEQ2)) ||
                 ((seq_len == 2'd3) && (cp < CP_MIN_SEQ3)) ||
                 ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI)) ||
                 (cp > CP_MAX);
    endfunction

endpackage

// ===== sv/virtual_path_utf8_validator_top.sv =====
// m_tvalid rises once the verdict of a final byte is in the result register.
// Throughput: one byte per cycle, set by the per-byte update of the core state.
// A request stalls only while a verdict waits in the result register.
// Reset: synchronous, active-low aresetn empties both registers and clears the
// decoder and segment state; no clearing pass follows.
`timescale 1ns / 1ps
module virtual_path_utf8_validator_top
    import vpu8_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] path_byte
    input  logic       s_tlast,   // last
    input  logic       s_tuser,   // empty_path
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [3:1] fault, [7:4] zero
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    logic    res_valid;
    result_t result;
    logic    out_free;
    result_t out_result;

    assign in_item = '{path_byte: s_tdata, last: s_tlast, empty_path: s_tuser};

    vpu8_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    vpu8_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item      (item),
        .item_take (item_take),
        .res_valid (res_valid),
        .result    (result)
    );

    assign item_take = item_valid && (!res_valid || out_free);

    vpu8_out_reg u_out_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (item_take && res_valid),
        .load_result (result),
        .out_free    (out_free),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    assign m_tdata = {4'd0, out_result.fault, out_result.valid_res};

endmodule

// ===== sv/vpu8_in_reg.sv =====
// Input register: holds one path byte request until the core takes it.
`timescale 1ns / 1ps
module vpu8_in_reg
    import vpu8_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    output item_t item,
    input  logic  item_take
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || item_take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/vpu8_core.sv =====
// Checker core: running UTF-8 and segment state and the per-byte update.
`timescale 1ns / 1ps
module vpu8_core
    import vpu8_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  item_t   item,
    input  logic    item_take,
    output logic    res_valid,
    output result_t result
);

`include "virtual_path_utf8_validator_top_assert.svh"

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_t     st;
        logic [7:0] b;
        st        = state_reg;
        b         = item.path_byte;
        res_valid = 1'b0;
        result    = '{fault: FAULT_OK, valid_res: 1'b0};
        if (item.empty_path) begin
            st           = STATE_RESET;
            res_valid    = 1'b1;
            result.fault = FAULT_EMPTY;
        end else begin
            if ((b == BYTE_NUL) || (b == BYTE_BACKSLASH) || (b == BYTE_COLON)) begin
                st.flags[FLAG_FORBIDDEN] = 1'b1;
            end
            if (st.pend != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    st.flags[FLAG_UTF8] = 1'b1;
                    st.pend             = 2'd0;
                end else begin
                    st.acc  = {st.acc[14:0], b[5:0]};
                    st.pend = st.pend - 2'd1;
                    if ((st.pend == 2'd0) && cp_bad(st.seq_len, st.acc)) begin
                        st.flags[FLAG_UTF8] = 1'b1;
                    end
                end
            end else if (b[7]) begin
                priority if (b[7:5] == 3'b110) begin
                    if (b[4:0] == 5'd0) begin
                        st.flags[FLAG_UTF8] = 1'b1;
                    end else begin
                        st.seq_len = 2'd1;
                        st.acc     = {16'd0, b[4:0]};
                        st.pend    = 2'd1;
                    end
                end else if (b[7:4] == 4'b1110) begin
                    st.seq_len = 2'd2;
                    st.acc     = {17'd0, b[3:0]};
                    st.pend    = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    st.seq_len = 2'd3;
                    st.acc     = {18'd0, b[2:0]};
                    st.pend    = 2'd3;
                end else begin
                    st.flags[FLAG_UTF8] = 1'b1;
                end
            end
            if (b == BYTE_SLASH) begin
                if (seg_bad(st.seg_len, st.seg_dots)) begin
                    st.flags[FLAG_SEGMENT] = 1'b1;
                end
                st.seg_len  = 2'd0;
                st.seg_dots = 1'b1;
            end else begin
                if (st.seg_len != SEG_LEN_SAT) begin
                    st.seg_len = st.seg_len + 2'd1;
                end
                if (b != BYTE_DOT) begin
                    st.seg_dots = 1'b0;
                end
            end
            if (item.last) begin
                if (st.pend != 2'd0) begin
                    st.flags[FLAG_UTF8] = 1'b1;
                end
                if (seg_bad(st.seg_len, st.seg_dots)) begin
                    st.flags[FLAG_SEGMENT] = 1'b1;
                end
                priority if (st.flags[FLAG_FORBIDDEN]) begin
                    result.fault = FAULT_FORBIDDEN;
                end else if (st.flags[FLAG_UTF8]) begin
                    result.fault = FAULT_UTF8;
                end else if (st.flags[FLAG_SEGMENT]) begin
                    result.fault = FAULT_SEGMENT;
                end else begin
                    result.fault = FAULT_OK;
                end
                result.valid_res = (result.fault == FAULT_OK);
                res_valid        = 1'b1;
                st               = STATE_RESET;
            end
        end
        state_next = st;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (item_take) begin
            state_reg <= state_next;
        end
    end

    `VPU8_ASSERT_NEXT(a_clear_after_result, item_take && res_valid,
        (state_reg.flags == 3'd0) && (state_reg.pend == 2'd0) && state_reg.seg_dots,
        "state not cleared after a verdict")
    `VPU8_ASSERT_NOW(a_pend_within_seq, state_reg.pend != 2'd0,
        state_reg.pend <= state_reg.seq_len,
        "more continuations pending than the sequence holds")
    `VPU8_ASSERT_NOW(a_empty_seg_all_dots, state_reg.seg_len == 2'd0,
        state_reg.seg_dots, "empty segment not marked all dots")

endmodule

// ===== sv/vpu8_out_reg.sv =====
// Result register: holds one verdict until the downstream side takes it.
`timescale 1ns / 1ps
module vpu8_out_reg
    import vpu8_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_result,
    output logic    out_free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
